FILE: rtl/core/clr_pkg.sv
// Shared types, widths and helpers for the clipped line rasterizer.
// No dependencies; imported by every module of the block.
package clr_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_IMAGE_SIZE = 4096;

  localparam int SIZE_W  = 13;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 24;
  localparam int DELTA_W = COORD_BITS + 1;
  localparam int ERR_W   = COORD_BITS + 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_IMAGE_SIZE);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_DROP  = 2'd2
  } item_kind_e;

  // One classified item as it travels from front to back.
  typedef struct packed {
    item_kind_e           kind;
    coord_t               start_x;
    coord_t               start_y;
    coord_t               end_x;
    coord_t               end_y;
    logic [COLOR_W-1:0]   color;
    logic [DELTA_W-1:0]   delta_x;
    logic [DELTA_W-1:0]   delta_y;
    logic                 step_x_neg;
    logic                 step_y_neg;
  } queue_entry_t;

  // Clamp the size register to 1..MAX_IMAGE_SIZE.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] r;
    r = size;
    if (size < SIZE_MIN) r = SIZE_MIN;
    else if (size > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  // Signed coordinate >= unsigned image size.
  function automatic logic coord_ge_size(input coord_t c, input logic [SIZE_W-1:0] size);
    logic signed [COORD_BITS:0] cw;
    logic signed [COORD_BITS:0] sw;
    cw = {c[COORD_BITS-1], c};
    sw = $signed({{(COORD_BITS + 1 - SIZE_W){1'b0}}, size});
    return cw >= sw;
  endfunction

  // |a - b| of two signed coordinates.
  function automatic logic [DELTA_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [DELTA_W-1:0] aw;
    logic signed [DELTA_W-1:0] bw;
    aw = {a[COORD_BITS-1], a};
    bw = {b[COORD_BITS-1], b};
    return (aw > bw) ? DELTA_W'(aw - bw) : DELTA_W'(bw - aw);
  endfunction

endpackage

FILE: rtl/core/clr_front.sv
// Front end: accepts items, marks culled starts as drops, sets up lines.
// Depends on clr_pkg.
module clr_front (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  clr_pkg::coord_t            start_x_i,
  input  clr_pkg::coord_t            start_y_i,
  input  clr_pkg::coord_t            end_x_i,
  input  clr_pkg::coord_t            end_y_i,
  input  logic [clr_pkg::COLOR_W-1:0] line_color_i,
  input  logic                       endpoint_invalid_i,
  input  logic [clr_pkg::SIZE_W-1:0] size_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output clr_pkg::queue_entry_t      q_entry_o
);
  import clr_pkg::*;

  logic culled;

  // Both endpoints beyond the same edge.
  assign culled =
      (start_x_i[COORD_BITS-1] && end_x_i[COORD_BITS-1]) ||
      (coord_ge_size(start_x_i, size_i) && coord_ge_size(end_x_i, size_i)) ||
      (start_y_i[COORD_BITS-1] && end_y_i[COORD_BITS-1]) ||
      (coord_ge_size(start_y_i, size_i) && coord_ge_size(end_y_i, size_i));

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.start_x    = start_x_i;
    q_entry_o.start_y    = start_y_i;
    q_entry_o.end_x      = end_x_i;
    q_entry_o.end_y      = end_y_i;
    q_entry_o.color      = line_color_i;
    q_entry_o.delta_x    = abs_diff(end_x_i, start_x_i);
    q_entry_o.delta_y    = abs_diff(end_y_i, start_y_i);
    q_entry_o.step_x_neg = !(start_x_i < end_x_i);
    q_entry_o.step_y_neg = !(start_y_i < end_y_i);
    if (op_i) begin
      q_entry_o.kind = KIND_TICK;
    end else if (endpoint_invalid_i || culled) begin
      q_entry_o.kind = KIND_DROP;
    end else begin
      q_entry_o.kind = KIND_START;
    end
  end

endmodule

FILE: rtl/core/clr_queue.sv
// Two-entry FIFO between front and back ends.
// Depends on clr_pkg.
module clr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  clr_pkg::queue_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output clr_pkg::queue_entry_t head_o
);
  import clr_pkg::*;

  queue_entry_t mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/core/clr_back.sv
// Back end: Bresenham walker state, one step per tick, output register.
// Depends on clr_pkg.
module clr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [clr_pkg::SIZE_W-1:0]  size_i,
  input  logic                        q_valid_i,
  input  clr_pkg::queue_entry_t       q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        write_enable_o,
  output logic [clr_pkg::PIX_W-1:0]   pixel_x_o,
  output logic [clr_pkg::PIX_W-1:0]   pixel_y_o,
  output logic [clr_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                        line_done_o
);
  import clr_pkg::*;

  logic                busy_q, busy_d;
  coord_t              cur_x_q, cur_x_d;
  coord_t              cur_y_q, cur_y_d;
  coord_t              tgt_x_q, tgt_y_q;
  logic [DELTA_W-1:0]  dx_q, dy_q;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic                sxn_q, syn_q;
  logic [COLOR_W-1:0]  color_q;

  logic                out_valid_q;
  logic                we_q, done_q;
  logic [PIX_W-1:0]    px_q, py_q;
  logic [COLOR_W-1:0]  pc_q;

  logic out_free, is_tick, do_step, do_load;
  logic in_image, at_end, leaving, last;
  logic ge_x, ge_y;
  logic signed [ERR_W:0] e2, dx_w, dy_w, err_w;
  logic mv_x, mv_y;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_tick  = q_head_i.kind == KIND_TICK;
  assign q_pop_o  = q_valid_i && (!is_tick || out_free);
  assign do_step  = q_pop_o && is_tick && busy_q;
  assign do_load  = q_pop_o && (q_head_i.kind == KIND_START);

  // Step decision for the current pixel.
  assign ge_x     = coord_ge_size(cur_x_q, size_i);
  assign ge_y     = coord_ge_size(cur_y_q, size_i);
  assign in_image = !cur_x_q[COORD_BITS-1] && !ge_x && !cur_y_q[COORD_BITS-1] && !ge_y;
  assign at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign leaving  = (cur_x_q[COORD_BITS-1] && sxn_q) || (ge_x && !sxn_q) ||
                    (cur_y_q[COORD_BITS-1] && syn_q) || (ge_y && !syn_q);
  assign last     = at_end || leaving;

  // Error term advance.
  assign e2    = {err_q, 1'b0};
  assign dx_w  = $signed({{(ERR_W + 1 - DELTA_W){1'b0}}, dx_q});
  assign dy_w  = $signed({{(ERR_W + 1 - DELTA_W){1'b0}}, dy_q});
  assign mv_x  = e2 > -dy_w;
  assign mv_y  = e2 < dx_w;
  assign err_w = {err_q[ERR_W-1], err_q} - (mv_x ? dy_w : '0) + (mv_y ? dx_w : '0);

  always_comb begin
    busy_d  = busy_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    if (q_pop_o) begin
      unique case (q_head_i.kind)
        KIND_START: begin
          busy_d  = 1'b1;
          cur_x_d = q_head_i.start_x;
          cur_y_d = q_head_i.start_y;
          err_d   = $signed({2'b00, q_head_i.delta_x}) - $signed({2'b00, q_head_i.delta_y});
        end
        KIND_DROP: begin
          busy_d = 1'b0;
        end
        KIND_TICK: begin
          if (busy_q) begin
            if (last) begin
              busy_d = 1'b0;
            end else begin
              err_d = err_w[ERR_W-1:0];
              if (mv_x) cur_x_d = sxn_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
              if (mv_y) cur_y_d = syn_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    err_q   <= err_d;
    if (do_load) begin
      tgt_x_q <= q_head_i.end_x;
      tgt_y_q <= q_head_i.end_y;
      dx_q    <= q_head_i.delta_x;
      dy_q    <= q_head_i.delta_y;
      sxn_q   <= q_head_i.step_x_neg;
      syn_q   <= q_head_i.step_y_neg;
      color_q <= q_head_i.color;
    end
    if (do_step) begin
      we_q   <= in_image;
      px_q   <= in_image ? cur_x_q[PIX_W-1:0] : '0;
      py_q   <= in_image ? cur_y_q[PIX_W-1:0] : '0;
      pc_q   <= color_q;
      done_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (do_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_color_o  = pc_q;
  assign line_done_o    = done_q;

endmodule

FILE: rtl/core/clipped_line_rasterizer_unit.sv
// Top level of the clipped Bresenham line rasterizer: size register,
// front end, item queue and walker. Depends on clr_pkg, clr_front,
// clr_queue, clr_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (image size)
//   in      | in        | in_valid_i/in_ready_o   | op, endpoints, color, invalid
//   out     | out       | out_valid_o/out_ready_i | write enable, pixel x/y,
//           |           |                         | color, line done
//
// One item per clock sustained unless the output stalls: the front end
// classifies an item in the cycle it is accepted, the walker takes one item
// from the 2-entry queue per clock and registers a tick's pixel as it pops it.
// A stalled output holds ticks in the queue; starts still drain past it
// only once they reach the head. Reset clears the queue, the busy flag and
// the output valid, and sets the image size to 256. Config is always ready.
module clipped_line_rasterizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [clr_pkg::SIZE_W-1:0]  cfg_data_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  clr_pkg::coord_t             start_x_i,
  input  clr_pkg::coord_t             start_y_i,
  input  clr_pkg::coord_t             end_x_i,
  input  clr_pkg::coord_t             end_y_i,
  input  logic [clr_pkg::COLOR_W-1:0] line_color_i,
  input  logic                        endpoint_invalid_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        write_enable_o,
  output logic [clr_pkg::PIX_W-1:0]   pixel_x_o,
  output logic [clr_pkg::PIX_W-1:0]   pixel_y_o,
  output logic [clr_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                        line_done_o
);
  import clr_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_eff;

  logic         q_push, q_full, q_pop, q_valid;
  queue_entry_t q_in, q_head;

  // Image size register; out-of-range values are clamped on use.
  assign cfg_ready_o = 1'b1;
  assign size_eff    = eff_size(size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  clr_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .line_color_i      (line_color_i),
    .endpoint_invalid_i(endpoint_invalid_i),
    .size_i            (size_eff),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_entry_o         (q_in)
  );

  clr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  clr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .size_i        (size_eff),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .write_enable_o(write_enable_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .line_done_o   (line_done_o)
  );

endmodule

FILE: test/clr_line_checker.sv
`timescale 1ns / 1ps
// Op codes shared with the testbench top, and the checker that predicts each
// line walk pixel by pixel and compares it with the block's output channel.
// Depends on clr_pkg.
package clr_line_tb_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } line_op_e;

endpackage

module clr_line_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [clr_pkg::SIZE_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        op_i,
  input  clr_pkg::coord_t             start_x_i,
  input  clr_pkg::coord_t             start_y_i,
  input  clr_pkg::coord_t             end_x_i,
  input  clr_pkg::coord_t             end_y_i,
  input  logic [clr_pkg::COLOR_W-1:0] line_color_i,
  input  logic                        endpoint_invalid_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        write_enable_i,
  input  logic [clr_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [clr_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic [clr_pkg::COLOR_W-1:0] pixel_color_i,
  input  logic                        line_done_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import clr_pkg::*;
  import clr_line_tb_pkg::*;

  typedef struct packed {
    logic               write_enable;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               line_done;
  } pixel_t;

  pixel_t                  pixel_q[$];
  pixel_t                  want_px;
  logic [SIZE_W-1:0]       size_reg;
  logic                    walking;
  coord_t                  cur_x, cur_y, goal_x, goal_y;
  logic [DELTA_W-1:0]      run_x, run_y;
  logic signed [ERR_W-1:0] err;
  logic                    back_x, back_y;
  logic [COLOR_W-1:0]      hue;
  int                      fails = 0;
  int                      pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Size register clamped to 1..MAX_IMAGE_SIZE.
  function automatic int image_extent();
    int s;
    s = int'(size_reg);
    if (s < 1) s = 1;
    if (s > MAX_IMAGE_SIZE) s = MAX_IMAGE_SIZE;
    return s;
  endfunction

  // A start always ends the current line; it only begins a new one when
  // both endpoints are valid and not beyond the same image edge.
  task automatic load_line(input coord_t x1, input coord_t y1, input coord_t x2,
                           input coord_t y2, input logic [COLOR_W-1:0] color,
                           input logic bad);
    int ext;
    ext = image_extent();
    walking = 1'b0;
    if (bad) return;
    if ((x1 < 0 && x2 < 0) || (x1 >= ext && x2 >= ext) ||
        (y1 < 0 && y2 < 0) || (y1 >= ext && y2 >= ext)) return;
    cur_x  = x1;
    cur_y  = y1;
    goal_x = x2;
    goal_y = y2;
    run_x  = DELTA_W'(x2 > x1 ? int'(x2) - int'(x1) : int'(x1) - int'(x2));
    run_y  = DELTA_W'(y2 > y1 ? int'(y2) - int'(y1) : int'(y1) - int'(y2));
    err    = ERR_W'(int'(run_x) - int'(run_y));
    back_x = !(x1 < x2);   // equal coordinates count as a negative step
    back_y = !(y1 < y2);
    hue    = color;
    walking = 1'b1;
  endtask

  // One Bresenham step: queue the pixel, then advance the error term.
  task automatic step_line();
    int   ext, cx, cy, e2;
    logic in_image, at_end, leaving, last;
    pixel_t px;
    ext = image_extent();
    cx = cur_x;
    cy = cur_y;
    in_image = cx >= 0 && cx < ext && cy >= 0 && cy < ext;
    at_end   = cur_x == goal_x && cur_y == goal_y;
    leaving  = (cx < 0 && back_x) || (cx >= ext && !back_x) ||
               (cy < 0 && back_y) || (cy >= ext && !back_y);
    last = at_end || leaving;
    px.write_enable = in_image;
    px.pixel_x      = in_image ? cur_x[PIX_W-1:0] : '0;
    px.pixel_y      = in_image ? cur_y[PIX_W-1:0] : '0;
    px.pixel_color  = hue;
    px.line_done    = last;
    pixel_q.push_back(px);
    if (last) begin
      walking = 1'b0;
    end else begin
      e2 = 2 * int'(err);
      if (e2 > -int'(run_y)) begin
        err = ERR_W'(int'(err) - int'(run_y));
        cx += back_x ? -1 : 1;
      end
      if (e2 < int'(run_x)) begin
        err = ERR_W'(int'(err) + int'(run_x));
        cy += back_y ? -1 : 1;
      end
      cur_x = coord_t'(cx);
      cur_y = coord_t'(cy);
    end
  endtask

  // Output first: a pixel leaving now was caused by an earlier item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q.delete();
      size_reg = SIZE_RESET;
      walking  = 1'b0;
      cur_x    = '0;
      cur_y    = '0;
      goal_x   = '0;
      goal_y   = '0;
      run_x    = '0;
      run_y    = '0;
      err      = '0;
      back_x   = 1'b0;
      back_y   = 1'b0;
      hue      = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel: we=%0b x=%0d y=%0d color=%06h done=%0b",
                 write_enable_i, pixel_x_i, pixel_y_i, pixel_color_i, line_done_i);
          fails++;
        end else begin
          want_px = pixel_q.pop_front();
          if (write_enable_i !== want_px.write_enable) begin
            $error("write_enable: expected %0b, got %0b",
                   want_px.write_enable, write_enable_i);
            fails++;
          end
          if (pixel_x_i !== want_px.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want_px.pixel_x, pixel_x_i);
            fails++;
          end
          if (pixel_y_i !== want_px.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want_px.pixel_y, pixel_y_i);
            fails++;
          end
          if (pixel_color_i !== want_px.pixel_color) begin
            $error("pixel_color: expected %06h, got %06h",
                   want_px.pixel_color, pixel_color_i);
            fails++;
          end
          if (line_done_i !== want_px.line_done) begin
            $error("line_done: expected %0b, got %0b", want_px.line_done, line_done_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) size_reg = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_TICK) begin
          if (walking) step_line();
        end else begin
          load_line(start_x_i, start_y_i, end_x_i, end_y_i, line_color_i,
                    endpoint_invalid_i);
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

FILE: test/clipped_line_rasterizer_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for clipped_line_rasterizer_unit: drives config, line starts
// and ticks, paces the pixel receiver, and gives the verdict.
// Depends on clr_pkg, clr_line_tb_pkg and clr_line_checker.
module clipped_line_rasterizer_unit_test;
  import clr_pkg::*;
  import clr_line_tb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 300;   // long receiver stall
  localparam int SETTLE_CYCLES = 8;     // lets the block's pipeline empty
  localparam int ITEM_TARGET   = 1950;
  localparam int CALM_ITEMS    = 150;   // tail of the run with no idling
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_PHASE    = 6;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [SIZE_W-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               op_i;
  coord_t             start_x_i, start_y_i, end_x_i, end_y_i;
  logic [COLOR_W-1:0] line_color_i;
  logic               endpoint_invalid_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               write_enable_o;
  logic [PIX_W-1:0]   pixel_x_o, pixel_y_o;
  logic [COLOR_W-1:0] pixel_color_o;
  logic               line_done_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int sent = 0;        // items that count toward the run length
  bit calm = 1'b0;     // no idling on either side once set
  bit gaps_on = 1'b1;  // sender gaps allowed in this phase
  bit hold_req = 1'b0; // asks the receiver for one long stall

  always #1 clk_i = ~clk_i;

  clipped_line_rasterizer_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .start_x_i          (start_x_i),
    .start_y_i          (start_y_i),
    .end_x_i            (end_x_i),
    .end_y_i            (end_y_i),
    .line_color_i       (line_color_i),
    .endpoint_invalid_i (endpoint_invalid_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .write_enable_o     (write_enable_o),
    .pixel_x_o          (pixel_x_o),
    .pixel_y_o          (pixel_y_o),
    .pixel_color_o      (pixel_color_o),
    .line_done_o        (line_done_o)
  );

  clr_line_checker u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .op_i               (op_i),
    .start_x_i          (start_x_i),
    .start_y_i          (start_y_i),
    .end_x_i            (end_x_i),
    .end_y_i            (end_y_i),
    .line_color_i       (line_color_i),
    .endpoint_invalid_i (endpoint_invalid_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .write_enable_i     (write_enable_o),
    .pixel_x_i          (pixel_x_o),
    .pixel_y_i          (pixel_y_o),
    .pixel_color_i      (pixel_color_o),
    .line_done_i        (line_done_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("clipped_line_rasterizer_unit_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pixel receiver: random ready and stall bursts, one long stall on request
  // so the block's small queue fills and backs up the input, steady at the end.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Offer one item and return at the edge that takes it; valid stays high so
  // the next item can follow with no bubble. Ready is sampled at the falling
  // edge, where every signal has settled.
  task automatic send_item(input line_op_e op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic [COLOR_W-1:0] color, input logic bad);
    bit taken;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    op_i               <= op;
    start_x_i          <= sx;
    start_y_i          <= sy;
    end_x_i            <= ex;
    end_y_i            <= ey;
    line_color_i       <= color;
    endpoint_invalid_i <= bad;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // A tick's other fields are don't-care; fill them with noise.
  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom),
                         COLOR_W'($urandom), 1'($urandom));
  endtask

  // Start plus ticks; spare ticks land after the line ends and are ignored,
  // so they don't count toward the run length.
  task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [COLOR_W-1:0] color, input logic bad,
                           input int ticks, input int spare);
    send_item(OP_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
              color, bad);
    send_ticks(ticks + spare);
    sent += 1 + ticks;
  endtask

  // Stop offering, wait for every predicted pixel, then let the pipe empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly short lines around the image, some cut short by the next start;
  // a few with full-range noisy coordinates and a few with invalid endpoints.
  task automatic random_line(input int ext);
    int kind, span, sx, sy, ex, ey, len, ylen, n;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      send_line(int'(coord_t'($urandom)), int'(coord_t'($urandom)),
                int'(coord_t'($urandom)), int'(coord_t'($urandom)),
                COLOR_W'($urandom), 1'($urandom), $urandom_range(0, 6), 0);
    end else if (kind == 1) begin
      send_line($urandom_range(0, ext - 1), $urandom_range(0, ext - 1),
                $urandom_range(0, ext - 1), $urandom_range(0, ext - 1),
                COLOR_W'($urandom), 1'b1, 0, 1);
    end else begin
      span = (ext < 60) ? ext + 6 : 60;
      sx = int'($urandom_range(0, ext + 7)) - 4;
      sy = int'($urandom_range(0, ext + 7)) - 4;
      ex = sx + int'($urandom_range(0, 2 * span)) - span;
      ey = sy + int'($urandom_range(0, 2 * span)) - span;
      len  = (ex > sx) ? ex - sx : sx - ex;
      ylen = (ey > sy) ? ey - sy : sy - ey;
      if (ylen > len) len = ylen;
      len = len + 1;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len) : len;
      send_line(sx, sy, ex, ey, COLOR_W'($urandom), 1'b0, n, $urandom_range(0, 2));
    end
  endtask

  initial begin
    int phase_sizes[12] = '{1, 4096, 8191, 0, 2, 33, 256, 700, 3000, 4095, 128, 9};
    int size_val, ext, p, phase_end;

    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    op_i               <= OP_START;
    start_x_i          <= '0;
    start_y_i          <= '0;
    end_x_i            <= '0;
    end_y_i            <= '0;
    line_color_i       <= '0;
    endpoint_invalid_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, image size at its reset value of 256.
    send_ticks(1);                                          // tick while idle
    sent += 1;
    send_line(0, 0, 3, 2, 24'h000000, 1'b0, 4, 1);          // plain shallow line
    send_line(7, 7, 7, 7, 24'hFFFFFF, 1'b0, 1, 1);          // single point
    send_line(1, 1, 4, 4, 24'h123456, 1'b1, 0, 1);          // invalid endpoint
    send_line(-5, 3, -1, 9, 24'h0000FF, 1'b0, 0, 0);        // both left of image
    send_line(300, 5, 256, 9, 24'h00FF00, 1'b0, 0, 0);      // both right
    send_line(5, -1, 9, -32768, 24'hFF0000, 1'b0, 0, 0);    // both above
    send_line(3, 256, 9, 400, 24'hABCDEF, 1'b0, 0, 1);      // both below
    send_line(-32768, -32768, 32767, 32767, 24'hA5A5A5, 1'b0, 2, 0); // abandoned
    send_line(200, 200, 195, 150, 24'h5A5A5A, 1'b0, 3, 0);  // steep, negative steps
    send_line(253, 100, 300, 103, 24'h777777, 1'b0, 4, 1);  // walks out the right edge
    // Size change between ticks of one line: the next ticks use the new size.
    send_line(254, 10, 270, 10, 24'h888888, 1'b0, 1, 0);
    drain_results();
    write_size(SIZE_W'(258));
    send_ticks(4);
    sent += 4;
    send_ticks(1);

    // Random phases, one image size each; extremes and clamped values first.
    p = 0;
    ext = 256;
    while (sent < ITEM_TARGET - CALM_ITEMS) begin
      size_val = (p < 12) ? phase_sizes[p] : $urandom_range(1, 8191);
      drain_results();
      write_size(SIZE_W'(size_val));
      ext = (size_val < 1) ? 1 : (size_val > MAX_IMAGE_SIZE) ? MAX_IMAGE_SIZE : size_val;
      gaps_on = ($urandom_range(0, 2) != 0);
      if (p == HOLD_PHASE) begin
        // Long line while the receiver stalls: the input must back up.
        hold_req = 1'b1;
        send_line(5, 5, 120, 70, COLOR_W'($urandom), 1'b0, 116, 0);
      end
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < ITEM_TARGET - CALM_ITEMS) random_line(ext);
      p++;
    end

    calm = 1'b1;
    while (sent < ITEM_TARGET) random_line(ext);
    drain_results();

    if (fail_count == 0) begin
      $display("clipped_line_rasterizer_unit_test: clean");
    end else begin
      $display("clipped_line_rasterizer_unit_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/clr_pkg.sv
rtl/core/clr_front.sv
rtl/core/clr_queue.sv
rtl/core/clr_back.sv
rtl/core/clipped_line_rasterizer_unit.sv
test/clr_line_checker.sv
test/clipped_line_rasterizer_unit_test.sv
